### rtl/core/fct_pkg.sv
`timescale 1ns / 1ps

package fct_pkg;

    // Bitmap capacity: sets, tasks and fragments per group
    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 6;
    localparam int TAG_W    = 8;
    localparam int FIELD_W  = 8;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    typedef logic [CAPACITY-1:0] frag_map_t;
    typedef logic [CNT_W-1:0]    count_t;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_CHECK  = 2'd1,
        OP_RECORD = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_INIT     = 3'd1,
        ST_REQUEST  = 3'd2,
        ST_SET      = 3'd3,
        ST_TASK     = 3'd4,
        ST_FRAGMENT = 3'd5
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONFIGURED     = 3'd0,
        CFG_EXPECTED_REQ   = 3'd1,
        CFG_GENERAL_COUNT  = 3'd2,
        CFG_SET_COUNT      = 3'd3,
        CFG_PER_SET_COUNT  = 3'd4,
        CFG_TASK_COUNT     = 3'd5,
        CFG_PER_TASK_COUNT = 3'd6,
        CFG_UNUSED         = 3'd7
    } cfg_index_t;

    // Configuration as seen by the tracker, counts already clamped
    typedef struct packed {
        logic             configured;
        logic [TAG_W-1:0] expected_request;
        count_t           general_eff;
        count_t           set_eff;
        count_t           per_set_eff;
        count_t           task_eff;
        count_t           per_task_eff;
    } cfg_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [TAG_W-1:0]   request_tag;
        logic [FIELD_W-1:0] set_index;
        logic [FIELD_W-1:0] task_index;
        logic [FIELD_W-1:0] fragment_index;
    } item_t;

    function automatic count_t eff_count(input count_t n);
        if ({1'b0, n} > (CNT_W+1)'(CAPACITY)) begin
            return CNT_W'(CAPACITY);
        end
        return n;
    endfunction

    // n is already clamped to CAPACITY
    function automatic frag_map_t full_mask(input count_t n);
        if ({1'b0, n} >= (CNT_W+1)'(CAPACITY)) begin
            return '1;
        end
        return (frag_map_t'(1) << n[IDX_W-1:0]) - frag_map_t'(1);
    endfunction

endpackage

### rtl/core/fct_cfg_regs.sv
`timescale 1ns / 1ps

module fct_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [fct_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fct_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output fct_pkg::cfg_t                 cfg
);
    import fct_pkg::*;

    logic             configured_reg;
    logic [TAG_W-1:0] expected_request_reg;
    count_t           general_count_reg;
    count_t           set_count_reg;
    count_t           per_set_count_reg;
    count_t           task_count_reg;
    count_t           per_task_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            configured_reg       <= 1'b0;
            expected_request_reg <= '0;
            general_count_reg    <= '0;
            set_count_reg        <= '0;
            per_set_count_reg    <= '0;
            task_count_reg       <= '0;
            per_task_count_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_CONFIGURED:     configured_reg       <= cfg_wdata[0];
                CFG_EXPECTED_REQ:   expected_request_reg <= cfg_wdata[TAG_W-1:0];
                CFG_GENERAL_COUNT:  general_count_reg    <= cfg_wdata[CNT_W-1:0];
                CFG_SET_COUNT:      set_count_reg        <= cfg_wdata[CNT_W-1:0];
                CFG_PER_SET_COUNT:  per_set_count_reg    <= cfg_wdata[CNT_W-1:0];
                CFG_TASK_COUNT:     task_count_reg       <= cfg_wdata[CNT_W-1:0];
                CFG_PER_TASK_COUNT: per_task_count_reg   <= cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp counts to capacity
    always_comb begin
        cfg.configured       = configured_reg;
        cfg.expected_request = expected_request_reg;
        cfg.general_eff      = eff_count(general_count_reg);
        cfg.set_eff          = eff_count(set_count_reg);
        cfg.per_set_eff      = eff_count(per_set_count_reg);
        cfg.task_eff         = eff_count(task_count_reg);
        cfg.per_task_eff     = eff_count(per_task_count_reg);
    end

endmodule

### rtl/core/fct_tracker.sv
`timescale 1ns / 1ps

module fct_tracker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         advance,
    input  fct_pkg::item_t               item,
    input  fct_pkg::cfg_t                cfg,
    output logic [fct_pkg::STATUS_W-1:0] status,
    output logic                         all_complete
);
    import fct_pkg::*;

    frag_map_t general_reg,   general_next;
    frag_map_t set_done_reg,  set_done_next;
    frag_map_t task_done_reg, task_done_next;
    frag_map_t set_frag_reg  [CAPACITY];
    frag_map_t task_frag_reg [CAPACITY];

    status_t            status_c;
    logic               wr_gen, wr_set, wr_task, do_clear;
    logic               s_neg1, t_neg1, s_bad, t_bad, s_ovf, t_ovf;
    logic               frag_ge_gen, frag_ge_set, frag_ge_task;
    logic [IDX_W-1:0]   s_idx, t_idx;
    frag_map_t          frag_bit, set_row_new, task_row_new;
    logic               set_hit, task_hit;

    always_comb begin
        s_neg1 = (item.set_index  == '1);
        t_neg1 = (item.task_index == '1);
        s_bad  = item.set_index[FIELD_W-1]  && !s_neg1;
        t_bad  = item.task_index[FIELD_W-1] && !t_neg1;
        // Only meaningful where the index is non-negative
        s_ovf  = ({1'b0, item.set_index[FIELD_W-2:0]} >=
                  {{(FIELD_W-CNT_W){1'b0}}, cfg.set_eff});
        t_ovf  = ({1'b0, item.task_index[FIELD_W-2:0]} >=
                  {{(FIELD_W-CNT_W){1'b0}}, cfg.task_eff});
        frag_ge_gen  = item.fragment_index >= {{(FIELD_W-CNT_W){1'b0}}, cfg.general_eff};
        frag_ge_set  = item.fragment_index >= {{(FIELD_W-CNT_W){1'b0}}, cfg.per_set_eff};
        frag_ge_task = item.fragment_index >= {{(FIELD_W-CNT_W){1'b0}}, cfg.per_task_eff};

        s_idx    = item.set_index[IDX_W-1:0];
        t_idx    = item.task_index[IDX_W-1:0];
        frag_bit = frag_map_t'(1) << item.fragment_index[IDX_W-1:0];

        status_c = ST_OK;
        wr_gen   = 1'b0;
        wr_set   = 1'b0;
        wr_task  = 1'b0;
        do_clear = 1'b0;

        case (op_t'(item.op))
            OP_CLEAR: begin
                do_clear = 1'b1;
            end
            OP_CHECK: begin
                if (!cfg.configured) begin
                    status_c = ST_INIT;
                end else if (item.request_tag != cfg.expected_request) begin
                    status_c = ST_REQUEST;
                end else if (s_bad) begin
                    status_c = ST_SET;
                end else if (t_bad) begin
                    status_c = ST_TASK;
                end else if (t_neg1) begin
                    if (s_neg1) begin
                        status_c = frag_ge_gen ? ST_FRAGMENT : ST_OK;
                    end else if (s_ovf) begin
                        status_c = ST_SET;
                    end else begin
                        status_c = frag_ge_set ? ST_FRAGMENT : ST_OK;
                    end
                end else if (t_ovf) begin
                    status_c = ST_TASK;
                end else begin
                    status_c = frag_ge_task ? ST_FRAGMENT : ST_OK;
                end
            end
            OP_RECORD: begin
                if (!cfg.configured) begin
                    status_c = ST_FRAGMENT;
                end else if (s_neg1) begin
                    if (frag_ge_gen) status_c = ST_FRAGMENT;
                    else             wr_gen   = 1'b1;
                end else if (t_neg1) begin
                    if (item.set_index[FIELD_W-1] || s_ovf) status_c = ST_SET;
                    else if (frag_ge_set)                   status_c = ST_FRAGMENT;
                    else                                    wr_set   = 1'b1;
                end else if (item.task_index[FIELD_W-1] || t_ovf) begin
                    status_c = ST_TASK;
                end else if (frag_ge_task) begin
                    status_c = ST_FRAGMENT;
                end else begin
                    wr_task = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Read-modify-write of the selected row
    always_comb begin
        set_row_new  = set_frag_reg[s_idx]  | frag_bit;
        task_row_new = task_frag_reg[t_idx] | frag_bit;
        set_hit      = (set_row_new  == full_mask(cfg.per_set_eff));
        task_hit     = (task_row_new == full_mask(cfg.per_task_eff));

        general_next   = general_reg;
        set_done_next  = set_done_reg;
        task_done_next = task_done_reg;
        if (do_clear) begin
            general_next   = '0;
            set_done_next  = '0;
            task_done_next = '0;
        end else begin
            if (wr_gen)             general_next   = general_reg   | frag_bit;
            if (wr_set && set_hit)  set_done_next  = set_done_reg  | (frag_map_t'(1) << s_idx);
            if (wr_task && task_hit) task_done_next = task_done_reg | (frag_map_t'(1) << t_idx);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            general_reg   <= '0;
            set_done_reg  <= '0;
            task_done_reg <= '0;
            for (int i = 0; i < CAPACITY; i++) begin
                set_frag_reg[i]  <= '0;
                task_frag_reg[i] <= '0;
            end
        end else if (advance) begin
            general_reg   <= general_next;
            set_done_reg  <= set_done_next;
            task_done_reg <= task_done_next;
            if (do_clear) begin
                for (int i = 0; i < CAPACITY; i++) begin
                    set_frag_reg[i]  <= '0;
                    task_frag_reg[i] <= '0;
                end
            end else begin
                if (wr_set)  set_frag_reg[s_idx]  <= set_row_new;
                if (wr_task) task_frag_reg[t_idx] <= task_row_new;
            end
        end
    end

    assign status = status_c;

    // Completion as seen after this item's update
    assign all_complete = cfg.configured
        && (cfg.general_eff == '0 || general_next   == full_mask(cfg.general_eff))
        && (cfg.set_eff     == '0 || set_done_next  == full_mask(cfg.set_eff))
        && (cfg.task_eff    == '0 || task_done_next == full_mask(cfg.task_eff));

endmodule

### rtl/core/fragment_completeness_tracker_top.sv
`timescale 1ns / 1ps

// Fragment completeness tracker.
// Input channel (s_valid/s_ready) carries one operation per transfer: clear
// all bitmaps, check a fragment header, record a fragment or do nothing.
// Output channel (m_valid/m_ready) returns exactly one result per input
// transfer: a status code and the message-complete flag as it stands after
// that operation. Configuration is written one register per cycle through
// cfg_wr_en/cfg_index/cfg_wdata; the user must write it only while no
// operation is in flight, which the block does not enforce. A transfer
// waits in the input register until the output register has room, then is
// evaluated; its result is registered as the bitmaps are updated.
// One transfer per cycle while m_ready stays high; row updates take effect
// with the result, so back-to-back operations see each other's updates.
// Reset (aresetn low, synchronous) clears configuration, all bitmaps and
// both valid flags. When the receiver holds m_ready low, the result holds in
// the output register while one more transfer may wait in the input
// register; s_ready then drops until the result is taken.
module fragment_completeness_tracker_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [fct_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fct_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [fct_pkg::OP_W-1:0]        s_op,
    input  logic [fct_pkg::TAG_W-1:0]       s_request_tag,
    input  logic signed [fct_pkg::FIELD_W-1:0] s_set_index,
    input  logic signed [fct_pkg::FIELD_W-1:0] s_task_index,
    input  logic [fct_pkg::FIELD_W-1:0]     s_fragment_index,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [fct_pkg::STATUS_W-1:0]    m_status,
    output logic                            m_all_complete
);
    import fct_pkg::*;

    cfg_t  cfg;
    item_t item_reg, item_next;
    logic  in_valid_reg, in_valid_next;
    logic  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic  all_complete_reg, all_complete_next;
    logic  advance, s_xfer;
    logic [STATUS_W-1:0] eval_status;
    logic  eval_complete;

    fct_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Evaluate the held item once the output register has room
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_xfer  = s_valid && s_ready;

    fct_tracker u_tracker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (advance),
        .item         (item_reg),
        .cfg          (cfg),
        .status       (eval_status),
        .all_complete (eval_complete)
    );

    always_comb begin
        item_next = item_reg;
        if (s_xfer) begin
            item_next.op             = s_op;
            item_next.request_tag    = s_request_tag;
            item_next.set_index      = s_set_index;
            item_next.task_index     = s_task_index;
            item_next.fragment_index = s_fragment_index;
        end

        // Load on transfer, drop once handed to the output stage
        if (s_xfer)       in_valid_next = 1'b1;
        else if (advance) in_valid_next = 1'b0;
        else              in_valid_next = in_valid_reg;

        status_next       = status_reg;
        all_complete_next = all_complete_reg;
        if (advance) begin
            out_valid_next    = 1'b1;
            status_next       = eval_status;
            all_complete_next = eval_complete;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        item_reg         <= item_next;
        status_reg       <= status_next;
        all_complete_reg <= all_complete_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_status       = status_reg;
    assign m_all_complete = all_complete_reg;

endmodule
